[design/trapmp_pkg.sv]
package trapmp_pkg;

   // Default word width of positions, velocities and limits.
   localparam int DEFAULT_VALUE_WIDTH = 32;

   // Width of the unsigned Q0.16 time step, which is also the multiplier chunk width.
   localparam int TIME_BITS = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VELOCITY       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ACCELERATION   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POSITION_TOLERANCE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VELOCITY_TOLERANCE = 2'd3;

   // Item commands.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

endpackage

[design/trapezoidal_motion_profile.sv]
// A tick item passes through the error, multiply, round, velocity add and clamp, position
// multiply, round, add and saturate, snap and finished check states; a load item goes straight to
// the finished check. One item is taken at a time, and a result waits while the output is stalled.
// The shared multiplier takes one 16-bit chunk a cycle.
// Reset is synchronous and active high; it clears position, velocity, goal, every
// configuration register and the result valid flag.
module trapezoidal_motion_profile
   import trapmp_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic signed [VALUE_WIDTH-1:0] req_start_position,
   input  logic signed [VALUE_WIDTH-1:0] req_target_position,
   input  logic [TIME_BITS-1:0]          req_time_step,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_position,
   output logic signed [VALUE_WIDTH-1:0] rsp_velocity,
   output logic                          rsp_done_res,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [VALUE_WIDTH-2:0]        csr_data
);

   localparam int W   = VALUE_WIDTH;
   localparam int MW  = W + 1;
   localparam int NCH = (W + TIME_BITS) / TIME_BITS;
   localparam int BW  = NCH * TIME_BITS;
   localparam int PW  = BW + MW;
   localparam int CW  = $clog2(NCH);
   localparam int RW  = W + TIME_BITS + 1;
   localparam logic [RW-1:0] RND_HALF = RW'(1) << (TIME_BITS - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(NCH - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ERR    = 4'd1;
   localparam logic [3:0] ST_LHS    = 4'd2;
   localparam logic [3:0] ST_RHS    = 4'd3;
   localparam logic [3:0] ST_ACC    = 4'd4;
   localparam logic [3:0] ST_AROUND = 4'd5;
   localparam logic [3:0] ST_VADD   = 4'd6;
   localparam logic [3:0] ST_VCLAMP = 4'd7;
   localparam logic [3:0] ST_PSETUP = 4'd8;
   localparam logic [3:0] ST_PMUL   = 4'd9;
   localparam logic [3:0] ST_PROUND = 4'd10;
   localparam logic [3:0] ST_PADD   = 4'd11;
   localparam logic [3:0] ST_PSAT   = 4'd12;
   localparam logic [3:0] ST_SNAP   = 4'd13;
   localparam logic [3:0] ST_DERR   = 4'd14;
   localparam logic [3:0] ST_DCMP   = 4'd15;

   logic [3:0]          state_ff, state_in;
   logic signed [W-1:0] pos_ff, pos_in;
   logic signed [W-1:0] vel_ff, vel_in;
   logic signed [W-1:0] goal_ff, goal_in;
   logic [W-2:0]        vmax_ff, vmax_in;
   logic [W-2:0]        amax_ff, amax_in;
   logic [W-2:0]        ptol_ff, ptol_in;
   logic [W-2:0]        vtol_ff, vtol_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                dir_ff, dir_in;
   logic                neg_ff, neg_in;
   logic [MW-1:0]       ma_ff, ma_in;
   logic [BW-1:0]       mb_ff, mb_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                first_ff, first_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic [PW-1:0]       lhs_ff, lhs_in;
   logic [W-1:0]        rnd_ff, rnd_in;
   logic signed [W:0]   sum_ff, sum_in;
   logic [MW-1:0]       err_mag_ff, err_mag_in;
   logic [W-1:0]        vel_mag_ff, vel_mag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] rsp_position_ff, rsp_position_in;
   logic signed [W-1:0] rsp_velocity_ff, rsp_velocity_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [MW+TIME_BITS-1:0] prod;
   logic [PW-1:0]       acc_step;
   logic signed [W:0]   err_diff;
   logic [W:0]          err_rev;
   logic [MW-1:0]       err_mag;
   logic [W-1:0]        vel_abs;
   logic [RW-1:0]       rnd_sum;
   logic [W-1:0]        rnd_calc;
   logic [W:0]          rnd_addend;
   logic [W:0]          rnd_ext;
   logic                clamp_hi;
   logic [W+1:0]        clamp_lo_sum;
   logic                clamp_lo;
   logic [W-1:0]        neg_vmax;
   logic [W-1:0]        clamp_val;
   logic                snap_hit;
   logic                accel;
   logic                mul_last;

   // Shared multiplier: one 16-bit chunk of the second operand a cycle, most significant first.
   assign prod     = ma_ff * mb_ff[BW-1 -: TIME_BITS];
   assign acc_step = (first_ff ? '0 : (acc_ff << TIME_BITS)) + PW'(prod);
   assign mul_last = (cnt_ff == '0);

   // Distance to the goal and its magnitude, both signs formed side by side.
   assign err_diff = {goal_ff[W-1], goal_ff} - {pos_ff[W-1], pos_ff};
   assign err_rev  = {pos_ff[W-1], pos_ff} - {goal_ff[W-1], goal_ff};
   assign err_mag  = err_diff[W] ? err_rev : err_diff;
   assign vel_abs  = vel_ff[W-1] ? ('0 - vel_ff) : vel_ff;

   // Rounding of a product by the time step back to the value scale, ties away from zero.
   assign rnd_sum  = {1'b0, acc_ff[W+TIME_BITS-1:0]} + RND_HALF;
   assign rnd_calc = rnd_sum[W+TIME_BITS-1:TIME_BITS];
   assign rnd_ext  = {1'b0, rnd_ff};

   // The add states apply the rounded step with its sign as a carry-in subtract.
   always_comb begin
      if (state_ff == ST_VADD) begin
         rnd_addend = neg_ff ? ~rnd_ext : rnd_ext;
      end else begin
         rnd_addend = vel_ff[W-1] ? ~rnd_ext : rnd_ext;
      end
   end

   // Velocity clamp against plus or minus the limit.
   assign clamp_hi     = sum_ff > $signed({2'b00, vmax_ff});
   assign clamp_lo_sum = {sum_ff[W], sum_ff} + {3'b000, vmax_ff};
   assign clamp_lo     = clamp_lo_sum[W+1];
   assign neg_vmax     = '0 - {1'b0, vmax_ff};
   assign clamp_val    = clamp_hi ? {1'b0, vmax_ff} : (clamp_lo ? neg_vmax : sum_ff[W-1:0]);

   // Reaching or passing the goal in the direction of travel.
   assign snap_hit = dir_ff ? (pos_ff >= goal_ff) : (pos_ff <= goal_ff);

   // Accelerate while twice the limit times the distance exceeds the squared speed.
   assign accel = lhs_ff > acc_ff;

   // Sequencer and datapath next values.
   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      vel_in          = vel_ff;
      goal_in         = goal_ff;
      vmax_in         = vmax_ff;
      amax_in         = amax_ff;
      ptol_in         = ptol_ff;
      vtol_in         = vtol_ff;
      time_in         = time_ff;
      dir_in          = dir_ff;
      neg_in          = neg_ff;
      ma_in           = ma_ff;
      mb_in           = mb_ff;
      cnt_in          = cnt_ff;
      first_in        = first_ff;
      acc_in          = acc_ff;
      lhs_in          = lhs_ff;
      rnd_in          = rnd_ff;
      sum_in          = sum_ff;
      err_mag_in      = err_mag_ff;
      vel_mag_in      = vel_mag_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_position_in = rsp_position_ff;
      rsp_velocity_in = rsp_velocity_ff;
      rsp_done_in     = rsp_done_ff;

      // Configuration writes.
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_VELOCITY:       vmax_in = csr_data;
            CSR_MAX_ACCELERATION:   amax_in = csr_data;
            CSR_POSITION_TOLERANCE: ptol_in = csr_data;
            CSR_VELOCITY_TOLERANCE: vtol_in = csr_data;
            default:                vmax_in = vmax_ff;
         endcase
      end

      // Multiply steps, common to every multiply state.
      if (state_ff == ST_LHS || state_ff == ST_RHS || state_ff == ST_ACC ||
          state_ff == ST_PMUL) begin
         acc_in   = acc_step;
         mb_in    = mb_ff << TIME_BITS;
         first_in = 1'b0;
         cnt_in   = cnt_ff - CW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  pos_in   = req_start_position;
                  goal_in  = req_target_position;
                  vel_in   = '0;
                  state_in = ST_DERR;
               end else begin
                  time_in  = req_time_step;
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            dir_in   = ~err_diff[W];
            ma_in    = err_mag;
            mb_in    = BW'({amax_ff, 1'b0});
            cnt_in   = CNT_FULL;
            first_in = 1'b1;
            state_in = ST_LHS;
         end
         ST_LHS: begin
            if (mul_last) begin
               ma_in    = MW'(vel_abs);
               mb_in    = BW'(vel_abs);
               cnt_in   = CNT_FULL;
               first_in = 1'b1;
               state_in = ST_RHS;
            end
         end
         ST_RHS: begin
            if (first_ff) begin
               lhs_in = acc_ff;
            end
            if (mul_last) begin
               ma_in    = MW'(amax_ff);
               mb_in    = {time_ff, {(BW-TIME_BITS){1'b0}}};
               cnt_in   = '0;
               first_in = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            neg_in   = (accel != dir_ff);
            state_in = ST_AROUND;
         end
         ST_AROUND: begin
            rnd_in   = rnd_calc;
            state_in = ST_VADD;
         end
         ST_VADD: begin
            sum_in   = {vel_ff[W-1], vel_ff} + rnd_addend + (W+1)'(neg_ff);
            state_in = ST_VCLAMP;
         end
         ST_VCLAMP: begin
            vel_in   = clamp_val;
            state_in = ST_PSETUP;
         end
         ST_PSETUP: begin
            ma_in    = MW'(vel_abs);
            mb_in    = {time_ff, {(BW-TIME_BITS){1'b0}}};
            cnt_in   = '0;
            first_in = 1'b1;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            state_in = ST_PROUND;
         end
         ST_PROUND: begin
            rnd_in   = rnd_calc;
            state_in = ST_PADD;
         end
         ST_PADD: begin
            sum_in   = {pos_ff[W-1], pos_ff} + rnd_addend + (W+1)'(vel_ff[W-1]);
            state_in = ST_PSAT;
         end
         ST_PSAT: begin
            if (sum_ff[W] != sum_ff[W-1]) begin
               pos_in = sum_ff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
               pos_in = sum_ff[W-1:0];
            end
            state_in = ST_SNAP;
         end
         ST_SNAP: begin
            if (snap_hit) begin
               pos_in = goal_ff;
               vel_in = '0;
            end
            state_in = ST_DERR;
         end
         ST_DERR: begin
            err_mag_in = err_mag;
            vel_mag_in = vel_abs;
            state_in   = ST_DCMP;
         end
         ST_DCMP: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = pos_ff;
               rsp_velocity_in = vel_ff;
               rsp_done_in     = (err_mag_ff <= {2'b00, ptol_ff}) &&
                                 (vel_mag_ff <= {1'b0, vtol_ff});
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         vel_ff       <= '0;
         goal_ff      <= '0;
         vmax_ff      <= '0;
         amax_ff      <= '0;
         ptol_ff      <= '0;
         vtol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         goal_ff      <= goal_in;
         vmax_ff      <= vmax_in;
         amax_ff      <= amax_in;
         ptol_ff      <= ptol_in;
         vtol_ff      <= vtol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      time_ff         <= time_in;
      dir_ff          <= dir_in;
      neg_ff          <= neg_in;
      ma_ff           <= ma_in;
      mb_ff           <= mb_in;
      cnt_ff          <= cnt_in;
      first_ff        <= first_in;
      acc_ff          <= acc_in;
      lhs_ff          <= lhs_in;
      rnd_ff          <= rnd_in;
      sum_ff          <= sum_in;
      err_mag_ff      <= err_mag_in;
      vel_mag_ff      <= vel_mag_in;
      rsp_position_ff <= rsp_position_in;
      rsp_velocity_ff <= rsp_velocity_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_velocity = rsp_velocity_ff;
   assign rsp_done_res = rsp_done_ff;

   // A load item clears the velocity and goes straight to the finished check.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_LOAD) |=>
      (vel_ff == '0 && state_ff == ST_DERR))
      else $error("load item did not clear velocity");

   // A result appears only out of the final compare state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DCMP))
      else $error("result raised outside the final compare state");

   // After the clamp the speed stays within the limit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VCLAMP) |=> (vel_abs <= {1'b0, vmax_ff}))
      else $error("velocity exceeds its limit after the clamp");

   // Reaching the goal leaves the block at the goal and at rest.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SNAP && snap_hit) |=> (pos_ff == goal_ff && vel_ff == '0))
      else $error("snap to goal did not take effect");

endmodule
